// ===== design/tdld_pkg.sv =====
// ----------------------------------------------------------------------------
// tdld_pkg
// Shared types, constants and helpers of the DPCM line decoder.
// ----------------------------------------------------------------------------
package tdld_pkg;

	// longest line in byte pairs, and the counter width that indexes it
	localparam int MAX_PAIRS = 2048;
	localparam int PAIR_W    = $clog2(MAX_PAIRS);
	localparam int LEN_W     = 12;

	// configuration port geometry: 64-bit registers at 8-byte spacing
	localparam int ADDR_W = 5;
	localparam int DATA_W = 64;

	// register indexes, taken from paddr[4:3]
	localparam logic [1:0] REG_DELTA_LOW  = 2'd0;
	localparam logic [1:0] REG_DELTA_HIGH = 2'd1;
	localparam logic [1:0] REG_PAIRS      = 2'd2;

	// reset line length in byte pairs
	localparam logic [LEN_W-1:0] PAIRS_RESET = LEN_W'(2);

	typedef struct packed {
		logic [15:0][7:0]   delta;
		logic [LEN_W-1:0]   pairs;
	} cfg_t;

	typedef struct packed {
		logic [7:0] luma;
		logic [7:0] chroma;
		logic       is_v;
		logic       line_end;
	} result_t;

	// signed delta entry as a raw byte, added modulo 256
	function automatic logic [7:0] delta_of(input logic [15:0][7:0] delta,
			input logic [3:0] idx);
		return delta[idx];
	endfunction

	// effective line length, clamped to the supported range
	function automatic logic [LEN_W-1:0] line_pairs(input logic [LEN_W-1:0] p);
		logic [LEN_W-1:0] r;
		r = p;
		if (r < LEN_W'(2)) begin
			r = LEN_W'(2);
		end
		if (r > LEN_W'(MAX_PAIRS)) begin
			r = LEN_W'(MAX_PAIRS);
		end
		return r;
	endfunction

endpackage

// ===== design/tdld_stream_if.sv =====
// ----------------------------------------------------------------------------
// tdld_stream_if
// Valid/ready channels for coded bytes in and decoded samples out.
// ----------------------------------------------------------------------------
interface tdld_code_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;

	modport source (output valid, output code_byte, input ready);
	modport sink (input valid, input code_byte, output ready);
endinterface

interface tdld_sample_if;
	logic       valid;
	logic       ready;
	logic [7:0] luma_sample;
	logic [7:0] chroma_sample;
	logic       chroma_is_v;
	logic       line_end;

	modport source (output valid, output luma_sample, output chroma_sample,
		output chroma_is_v, output line_end, input ready);
	modport sink (input valid, input luma_sample, input chroma_sample,
		input chroma_is_v, input line_end, output ready);
endinterface

// ===== design/tdld_predictor.sv =====
// ----------------------------------------------------------------------------
// tdld_predictor
// Predictor state and per-byte DPCM update for luma, U and V.
// ----------------------------------------------------------------------------
module tdld_predictor (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        code,
	input  tdld_pkg::cfg_t    cfg,
	output tdld_pkg::result_t res
);

	logic [7:0]                  luma_q;
	logic [7:0]                  u_q;
	logic [7:0]                  v_q;
	logic [tdld_pkg::PAIR_W-1:0] pair_q;
	logic                        odd_q;

	logic [7:0]                  luma_n;
	logic [7:0]                  u_n;
	logic [7:0]                  v_n;
	logic [tdld_pkg::PAIR_W-1:0] pair_n;
	logic                        line_end;
	logic                        start;
	logic [3:0]                  hi;
	logic [3:0]                  lo;
	logic [7:0]                  d_hi;
	logic [7:0]                  d_lo;
	logic [tdld_pkg::LEN_W-1:0]  next_pos;

	assign hi       = code[7:4];
	assign lo       = code[3:0];
	assign start    = (pair_q == '0);
	assign d_hi     = tdld_pkg::delta_of(cfg.delta, hi);
	assign d_lo     = tdld_pkg::delta_of(cfg.delta, lo);
	assign next_pos = tdld_pkg::LEN_W'(pair_q) + tdld_pkg::LEN_W'(1);

	// next predictor values for the byte at hand
	always_comb begin
		luma_n   = luma_q + d_lo;
		u_n      = u_q;
		v_n      = v_q;
		pair_n   = pair_q;
		line_end = 1'b0;
		if (!odd_q) begin
			if (start) begin
				u_n    = {hi, 4'h0};
				luma_n = {lo, 4'h0};
			end else begin
				u_n = u_q + d_hi;
			end
		end else begin
			v_n = start ? {hi, 4'h0} : v_q + d_hi;
			if (next_pos >= tdld_pkg::line_pairs(cfg.pairs)) begin
				line_end = 1'b1;
				pair_n   = '0;
			end else begin
				pair_n = next_pos[tdld_pkg::PAIR_W-1:0];
			end
		end
	end

	assign res.luma     = luma_n;
	assign res.chroma   = odd_q ? v_n : u_n;
	assign res.is_v     = odd_q;
	assign res.line_end = line_end;

	// predictor state, advanced once per decoded byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			luma_q <= '0;
			u_q    <= '0;
			v_q    <= '0;
			pair_q <= '0;
			odd_q  <= 1'b0;
		end else if (step) begin
			luma_q <= luma_n;
			u_q    <= u_n;
			v_q    <= v_n;
			pair_q <= pair_n;
			odd_q  <= ~odd_q;
		end
	end

	// a U byte leaves the pair position alone
	a_u_keeps_pair: assert property (@(posedge clk) disable iff (!arst_n)
		step && !odd_q |=> odd_q && $stable(pair_q))
		else $error("pair position moved on a U byte");

	// a line end returns to the first U byte of a line
	a_end_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		step && line_end |=> pair_q == '0 && !odd_q)
		else $error("line end did not restart the line");

	// line end only ever flags a V byte
	a_end_on_v: assert property (@(posedge clk) disable iff (!arst_n)
		line_end |-> odd_q)
		else $error("line end on a U byte");

endmodule

// ===== design/table_dpcm_yuv422_line_decoder.sv =====
// ----------------------------------------------------------------------------
// table_dpcm_yuv422_line_decoder
// Table-driven DPCM decoder for a YUV 4:2:2 line, one coded byte per sample.
// ----------------------------------------------------------------------------
// Takes one coded byte per cycle and returns one result per byte (luma and U
// on even bytes, luma and V on odd bytes). The byte is captured in an input
// register, the 8-bit table add per component sits between that register and
// the result register, and the result register lets the next byte enter
// while a result waits to be taken, so the sustained rate is one byte per
// clock while the receiver takes results. Registers sit on a 64-bit port at
// byte addresses 0 (deltas 0..7), 8 (deltas 8..15) and 16 (pairs per line);
// write them only while no byte is in flight. No clearing pass after reset.
module table_dpcm_yuv422_line_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tdld_pkg::ADDR_W-1:0]   paddr,
	input  logic [tdld_pkg::DATA_W-1:0]   pwdata,
	output logic [tdld_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	tdld_code_if.sink                     code_in,
	tdld_sample_if.source                 sample_out
);

	logic [63:0]                 delta_low_q;
	logic [63:0]                 delta_high_q;
	logic [tdld_pkg::LEN_W-1:0]  pairs_q;
	logic [1:0]                  reg_idx;
	logic                        cfg_wr;
	tdld_pkg::cfg_t              cfg;

	logic                        valid_s1;
	logic [7:0]                  code_s1;
	logic                        valid_s2;
	tdld_pkg::result_t           result_s2;
	tdld_pkg::result_t           res;
	logic                        advance;
	logic                        in_take;

	// configuration registers
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:3];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delta_low_q  <= '0;
			delta_high_q <= '0;
			pairs_q      <= tdld_pkg::PAIRS_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				tdld_pkg::REG_DELTA_LOW:  delta_low_q  <= pwdata;
				tdld_pkg::REG_DELTA_HIGH: delta_high_q <= pwdata;
				tdld_pkg::REG_PAIRS:      pairs_q      <= pwdata[tdld_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (reg_idx)
			tdld_pkg::REG_DELTA_LOW:  prdata = delta_low_q;
			tdld_pkg::REG_DELTA_HIGH: prdata = delta_high_q;
			tdld_pkg::REG_PAIRS:      prdata = tdld_pkg::DATA_W'(pairs_q);
			default:                  prdata = '0;
		endcase
	end

	assign cfg.delta = {delta_high_q, delta_low_q};
	assign cfg.pairs = pairs_q;

	// pipeline control: byte moves into the result register when it is free
	assign advance       = valid_s1 && (!valid_s2 || sample_out.ready);
	assign code_in.ready = !valid_s1 || advance;
	assign in_take       = code_in.valid && code_in.ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			code_s1 <= code_in.code_byte;
		end
	end

	tdld_predictor u_predictor (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.code   (code_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (sample_out.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= res;
		end
	end

	assign sample_out.valid         = valid_s2;
	assign sample_out.luma_sample   = result_s2.luma;
	assign sample_out.chroma_sample = result_s2.chroma;
	assign sample_out.chroma_is_v   = result_s2.is_v;
	assign sample_out.line_end      = result_s2.line_end;

	// a byte stalled in the input register keeps its value
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(code_s1))
		else $error("input register lost a stalled byte");

	// a result taken by the predictor always lands in the result register
	a_s2_fill: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("result register missed a decoded byte");

	// an accepted byte always occupies the input register
	a_s1_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> valid_s1)
		else $error("accepted byte not held in input register");

endmodule

// ===== verif/table_dpcm_yuv422_line_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// table_dpcm_yuv422_line_decoder_tb
// Self-checking testbench for the table-driven DPCM 4:2:2 line decoder.
// ----------------------------------------------------------------------------
// A short directed table runs first. It covers the reset state, both line
// starts, the nibble extremes, clamped line lengths and a line length that
// shrinks mid-line. Random phases follow, each with a fresh delta table and
// line length. A behavioral decoder predicts every sample. Both channels
// idle at random.
// ----------------------------------------------------------------------------
module table_dpcm_yuv422_line_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum bit {ROW_BYTE, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t           kind;
		logic [1:0]          reg_idx;
		logic [63:0]         wdata;
		logic [7:0]          code;
		bit                  typed;
		tdld_pkg::result_t   want;
	} row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [tdld_pkg::ADDR_W-1:0]   paddr;
	logic [tdld_pkg::DATA_W-1:0]   pwdata;
	logic [tdld_pkg::DATA_W-1:0]   prdata;
	logic                          pready;

	tdld_code_if   code_if ();
	tdld_sample_if sample_if ();

	table_dpcm_yuv422_line_decoder uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.code_in    (code_if),
		.sample_out (sample_if)
	);

	// decoder shadow: configuration
	logic [15:0][7:0] delta_tbl = '0;
	logic [11:0]      pairs_reg = 12'd2;

	// decoder shadow: line state
	logic [7:0] luma_acc  = 8'h00;
	logic [7:0] u_acc     = 8'h00;
	logic [7:0] v_acc     = 8'h00;
	int         pair_idx  = 0;
	bit         on_v_byte = 1'b0;

	tdld_pkg::result_t expected_samples[$];
	int                mismatch_count = 0;
	bit                steady = 1'b0;

	// typed expectation of the byte currently offered
	bit                typed_pending = 1'b0;
	tdld_pkg::result_t typed_want;

	row_t stim_tbl[$];

	always #1 clk = ~clk;

	// advance the shadow decoder by one coded byte
	function automatic tdld_pkg::result_t decode_byte(input logic [7:0] code);
		logic [3:0]        c_code;
		logic [3:0]        y_code;
		int                line_len;
		tdld_pkg::result_t r;
		c_code = code[7:4];
		y_code = code[3:0];
		line_len = pairs_reg;
		if (line_len < 2) begin
			line_len = 2;
		end
		if (line_len > tdld_pkg::MAX_PAIRS) begin
			line_len = tdld_pkg::MAX_PAIRS;
		end
		r.is_v = on_v_byte;
		r.line_end = 1'b0;
		if (!on_v_byte) begin
			if (pair_idx == 0) begin
				u_acc = {c_code, 4'h0};
				luma_acc = {y_code, 4'h0};
			end else begin
				u_acc = u_acc + delta_tbl[c_code];
				luma_acc = luma_acc + delta_tbl[y_code];
			end
			r.chroma = u_acc;
			on_v_byte = 1'b1;
		end else begin
			if (pair_idx == 0) begin
				v_acc = {c_code, 4'h0};
			end else begin
				v_acc = v_acc + delta_tbl[c_code];
			end
			luma_acc = luma_acc + delta_tbl[y_code];
			r.chroma = v_acc;
			on_v_byte = 1'b0;
			if (pair_idx + 1 >= line_len) begin
				r.line_end = 1'b1;
				pair_idx = 0;
			end else begin
				pair_idx++;
			end
		end
		r.luma = luma_acc;
		return r;
	endfunction

	function automatic row_t byte_row(input logic [7:0] code);
		row_t r;
		r = '{kind: ROW_BYTE, reg_idx: tdld_pkg::REG_DELTA_LOW, wdata: '0, code: code,
			typed: 1'b0, want: '0};
		return r;
	endfunction

	function automatic row_t typed_row(input logic [7:0] code, input logic [7:0] luma,
			input logic [7:0] chroma, input logic is_v, input logic line_end);
		row_t r;
		r = byte_row(code);
		r.typed = 1'b1;
		r.want = '{luma: luma, chroma: chroma, is_v: is_v, line_end: line_end};
		return r;
	endfunction

	function automatic row_t write_row(input logic [1:0] idx, input logic [63:0] value);
		row_t r;
		r = byte_row(8'h00);
		r.kind = ROW_WRITE;
		r.reg_idx = idx;
		r.wdata = value;
		return r;
	endfunction

	// offer one byte, with random gaps before it, until it is accepted
	task automatic send_byte(input logic [7:0] code, input bit typed,
			input tdld_pkg::result_t want);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 15) begin
			code_if.valid <= 1'b0;
			@(negedge clk);
		end
		code_if.valid <= 1'b1;
		code_if.code_byte <= code;
		typed_pending = typed;
		typed_want = want;
		do @(posedge clk); while (!code_if.ready);
	endtask

	// stop sending and let every outstanding sample come back
	task automatic wait_drain();
		@(negedge clk);
		code_if.valid <= 1'b0;
		while (expected_samples.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// register write: setup cycle, then access cycle
	task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			tdld_pkg::REG_DELTA_LOW:  delta_tbl[7:0] = value;
			tdld_pkg::REG_DELTA_HIGH: delta_tbl[15:8] = value;
			tdld_pkg::REG_PAIRS:      pairs_reg = value[11:0];
			default:                  ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// receiver stalls
	initial begin
		sample_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			sample_if.ready <= steady || ($urandom_range(0, 99) >= 15);
		end
	end

	// predict on each accepted byte, check each accepted sample
	always @(posedge clk) begin : watch_channels
		tdld_pkg::result_t predicted;
		tdld_pkg::result_t want;
		if (arst_n && code_if.valid && code_if.ready) begin
			predicted = decode_byte(code_if.code_byte);
			expected_samples.push_back(typed_pending ? typed_want : predicted);
		end
		if (arst_n && sample_if.valid && sample_if.ready) begin
			if (expected_samples.size() == 0) begin
				$error("sample transaction with nothing expected");
				mismatch_count++;
			end else begin
				want = expected_samples.pop_front();
				if (sample_if.luma_sample !== want.luma) begin
					$error("luma_sample: expected %h, got %h", want.luma,
						sample_if.luma_sample);
					mismatch_count++;
				end
				if (sample_if.chroma_sample !== want.chroma) begin
					$error("chroma_sample: expected %h, got %h", want.chroma,
						sample_if.chroma_sample);
					mismatch_count++;
				end
				if (sample_if.chroma_is_v !== want.is_v) begin
					$error("chroma_is_v: expected %b, got %b", want.is_v,
						sample_if.chroma_is_v);
					mismatch_count++;
				end
				if (sample_if.line_end !== want.line_end) begin
					$error("line_end: expected %b, got %b", want.line_end,
						sample_if.line_end);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog
	initial begin
		#1_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int          n_bytes;
		logic [11:0] pairs_val;
		logic [63:0] wval;

		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		code_if.valid = 1'b0;
		code_if.code_byte = 8'h00;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed rows: zero deltas after reset, then clamping and a shrinking line
		stim_tbl = '{
			typed_row(8'hA5, 8'h50, 8'hA0, 1'b0, 1'b0),
			typed_row(8'h3C, 8'h50, 8'h30, 1'b1, 1'b0),
			typed_row(8'hFF, 8'h50, 8'hA0, 1'b0, 1'b0),
			typed_row(8'h00, 8'h50, 8'h30, 1'b1, 1'b1),
			typed_row(8'hFF, 8'hF0, 8'hF0, 1'b0, 1'b0),
			typed_row(8'h00, 8'hF0, 8'h00, 1'b1, 1'b0),
			typed_row(8'h0F, 8'hF0, 8'hF0, 1'b0, 1'b0),
			typed_row(8'hF0, 8'hF0, 8'h00, 1'b1, 1'b1),
			write_row(tdld_pkg::REG_DELTA_LOW, 64'h807F_FF01_F010_FE02),
			write_row(tdld_pkg::REG_DELTA_HIGH, 64'h0180_7FFF_C040_807F),
			write_row(tdld_pkg::REG_PAIRS, 64'd0),
			byte_row(8'h00), byte_row(8'hFF), byte_row(8'h70),
			byte_row(8'h87), byte_row(8'h3C), byte_row(8'hC3),
			write_row(tdld_pkg::REG_PAIRS, 64'd1),
			byte_row(8'h96), byte_row(8'h69),
			write_row(tdld_pkg::REG_PAIRS, 64'hFFFF_FFFF_FFFF_FFFF),
			byte_row(8'h8F), byte_row(8'hF8), byte_row(8'h5A), byte_row(8'hA5),
			write_row(tdld_pkg::REG_PAIRS, 64'd2),
			byte_row(8'h11), byte_row(8'hEE)
		};
		foreach (stim_tbl[i]) begin
			if (stim_tbl[i].kind == ROW_WRITE) begin
				wait_drain();
				write_reg(stim_tbl[i].reg_idx, stim_tbl[i].wdata);
			end else begin
				send_byte(stim_tbl[i].code, stim_tbl[i].typed, stim_tbl[i].want);
			end
		end

		// random phases, each with its own table and line length
		for (int phase = 0; phase < 9; phase++) begin
			wait_drain();
			steady = (phase == 2);
			case ($urandom_range(0, 9))
				0:       pairs_val = 12'd0;
				1:       pairs_val = 12'd1;
				2:       pairs_val = 12'hFFF;
				3:       pairs_val = 12'($urandom_range(0, 4095));
				default: pairs_val = 12'($urandom_range(2, 12));
			endcase
			n_bytes = $urandom_range(30, 60);
			write_reg(tdld_pkg::REG_DELTA_LOW, {$urandom, $urandom});
			write_reg(tdld_pkg::REG_DELTA_HIGH, {$urandom, $urandom});
			wval = {$urandom, $urandom};
			wval[11:0] = pairs_val;
			write_reg(tdld_pkg::REG_PAIRS, wval);
			for (int k = 0; k < n_bytes; k++) begin
				send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
			end
		end
		steady = 1'b0;

		wait_drain();
		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
